[rtl/core/rofm_pkg.sv]
// shared constants, codes and types of the reference offset matcher
package rofm_pkg;

  // table sizes
  localparam int unsigned MASTER_ENTRIES = 16;
  localparam int unsigned OWN_ENTRIES    = 16;

  // field widths
  localparam int unsigned ACT_W  = 2;
  localparam int unsigned ID_W   = 64;
  localparam int unsigned TS_W   = 64;
  localparam int unsigned OFFS_W = 32;
  localparam int unsigned OIDX_W = 4;

  // derived widths
  localparam int unsigned MIDX_W = (MASTER_ENTRIES > 1) ? $clog2(MASTER_ENTRIES) : 1;
  localparam int unsigned LCNT_W = $clog2(MASTER_ENTRIES + 1);
  localparam int unsigned MCNT_W = $clog2(OWN_ENTRIES + 1);

  // action codes
  localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd0;
  localparam logic [ACT_W-1:0] ACT_LOAD  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_QUERY = 2'd2;

  // one master table entry
  typedef struct packed {
    logic [ID_W-1:0] id;
    logic [TS_W-1:0] stamp;
  } entry_t;

  // table write port
  typedef struct packed {
    logic              we;
    logic [MIDX_W-1:0] addr;
    entry_t            entry;
  } tbl_wr_t;

  // result handed from the sequencer to the output register
  typedef struct packed {
    logic                     valid;
    logic signed [OFFS_W-1:0] offset;
    logic [OIDX_W-1:0]        index;
  } res_t;

  // sequencer status
  typedef struct packed {
    logic              busy;
    logic [LCNT_W-1:0] load_count;
    logic [MCNT_W-1:0] match_count;
  } stat_t;

endpackage

[rtl/core/rofm_if.sv]
// request and result channel interfaces of the reference offset matcher
interface rofm_req_if;
  logic                             valid;
  logic                             ready;
  logic [rofm_pkg::ACT_W-1:0]       action;
  logic [rofm_pkg::ID_W-1:0]        ref_id;
  logic [rofm_pkg::TS_W-1:0]        ref_time;

  modport source(output valid, action, ref_id, ref_time, input ready);
  modport sink(input valid, action, ref_id, ref_time, output ready);
endinterface

interface rofm_res_if;
  logic                               valid;
  logic                               ready;
  logic signed [rofm_pkg::OFFS_W-1:0] offset;
  logic [rofm_pkg::OIDX_W-1:0]        offset_index;

  modport source(output valid, offset, offset_index, input ready);
  modport sink(input valid, offset, offset_index, output ready);
endinterface

[rtl/core/rofm_table.sv]
// master reference table: one write port, one registered read port
module rofm_table (
  input  logic                          clk_i,
  input  rofm_pkg::tbl_wr_t             wr_i,
  input  logic [rofm_pkg::MIDX_W-1:0]   raddr_i,
  output rofm_pkg::entry_t              rdata_o
);

  rofm_pkg::entry_t mem_q [rofm_pkg::MASTER_ENTRIES];
  rofm_pkg::entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem_q[wr_i.addr] <= wr_i.entry;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/rofm_seq.sv]
// scan sequencer: counters, id compare and offset subtract over the table
module rofm_seq (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  rofm_req_if.sink                      req_i,
  output rofm_pkg::tbl_wr_t             wr_o,
  output logic [rofm_pkg::MIDX_W-1:0]   raddr_o,
  input  rofm_pkg::entry_t              rdata_i,
  output rofm_pkg::res_t                res_o,
  input  logic                          res_ready_i,
  output rofm_pkg::stat_t               stat_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_READ = 2'd1;
  localparam logic [1:0] ST_CMP  = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  logic [1:0]                        state_q, state_d;
  logic [rofm_pkg::LCNT_W-1:0]       load_q, load_d;
  logic [rofm_pkg::MCNT_W-1:0]       match_q, match_d;
  logic [rofm_pkg::MIDX_W-1:0]       k_q, k_d;
  logic [rofm_pkg::ID_W-1:0]         key_id_q, key_id_d;
  logic [rofm_pkg::OFFS_W-1:0]       key_ts_q, key_ts_d;
  logic [rofm_pkg::OFFS_W-1:0]       offs_q, offs_d;
  logic                              acc;
  logic                              last;

  assign req_i.ready = (state_q == ST_IDLE);
  assign acc         = req_i.valid && req_i.ready;
  assign raddr_o     = k_q;
  assign last        = (rofm_pkg::LCNT_W'(k_q) + rofm_pkg::LCNT_W'(1)) == load_q;

  // table write on an accepted load with room left
  always_comb begin
    wr_o.we          = acc && (req_i.action == rofm_pkg::ACT_LOAD) &&
                       (load_q < rofm_pkg::LCNT_W'(rofm_pkg::MASTER_ENTRIES));
    wr_o.addr        = load_q[rofm_pkg::MIDX_W-1:0];
    wr_o.entry.id    = req_i.ref_id;
    wr_o.entry.stamp = req_i.ref_time;
  end

  always_comb begin
    state_d  = state_q;
    load_d   = load_q;
    match_d  = match_q;
    k_d      = k_q;
    key_id_d = key_id_q;
    key_ts_d = key_ts_q;
    offs_d   = offs_q;
    case (state_q)
      ST_IDLE: begin
        if (acc) begin
          case (req_i.action)
            rofm_pkg::ACT_CLEAR: begin
              load_d  = '0;
              match_d = '0;
            end
            rofm_pkg::ACT_LOAD: begin
              if (wr_o.we) begin
                load_d = load_q + rofm_pkg::LCNT_W'(1);
              end
            end
            rofm_pkg::ACT_QUERY: begin
              if ((match_q < rofm_pkg::MCNT_W'(rofm_pkg::OWN_ENTRIES)) && (load_q != '0)) begin
                key_id_d = req_i.ref_id;
                key_ts_d = req_i.ref_time[rofm_pkg::OFFS_W-1:0];
                k_d      = '0;
                state_d  = ST_READ;
              end
            end
            default: ;
          endcase
        end
      end
      ST_READ: begin
        state_d = ST_CMP;
      end
      ST_CMP: begin
        // first equal id in load order wins
        if (rdata_i.id == key_id_q) begin
          offs_d  = rdata_i.stamp[rofm_pkg::OFFS_W-1:0] - key_ts_q;
          state_d = ST_EMIT;
        end else if (last) begin
          state_d = ST_IDLE;
        end else begin
          k_d     = k_q + rofm_pkg::MIDX_W'(1);
          state_d = ST_READ;
        end
      end
      ST_EMIT: begin
        if (res_ready_i) begin
          match_d = match_q + rofm_pkg::MCNT_W'(1);
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      load_q  <= '0;
      match_q <= '0;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      load_q  <= load_d;
      match_q <= match_d;
      k_q     <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_id_q <= key_id_d;
    key_ts_q <= key_ts_d;
    offs_q   <= offs_d;
  end

  always_comb begin
    res_o.valid  = (state_q == ST_EMIT);
    res_o.offset = offs_q;
    res_o.index  = rofm_pkg::OIDX_W'(match_q);
  end

  always_comb begin
    stat_o.busy        = (state_q != ST_IDLE);
    stat_o.load_count  = load_q;
    stat_o.match_count = match_q;
  end

endmodule

[rtl/core/reference_offset_matcher.sv]
// top level of the reference offset matcher
//
// channel   dir  payload                          accepted when
// item_i    in   action, ref_id, ref_time         item_i.valid && item_i.ready
// result_o  out  offset, offset_index             result_o.valid && result_o.ready
//
// clear and load requests complete in the idle state; a query scans the live
// master entries in load order, each read then compared through the single
// table read port, and stops at the first match, which it then hands off
// rst_ni clears the sequencer, fill count, match count and output valid;
// table contents stay undefined, the fill count marks the live entries
// item_i.ready is low while a query scans or waits to hand off its match;
// a held result in the output register does not block new requests, only
// the handoff of the next match
module reference_offset_matcher (
  input  logic       clk_i,
  input  logic       rst_ni,
  rofm_req_if.sink   item_i,
  rofm_res_if.source result_o
);

  rofm_pkg::tbl_wr_t                 tbl_wr;
  logic [rofm_pkg::MIDX_W-1:0]       tbl_raddr;
  rofm_pkg::entry_t                  tbl_rdata;
  rofm_pkg::res_t                    res;
  rofm_pkg::stat_t                   stat;
  logic                              res_ready;

  // output register state
  logic                              out_valid_q;
  logic signed [rofm_pkg::OFFS_W-1:0] out_offs_q;
  logic [rofm_pkg::OIDX_W-1:0]       out_idx_q;

  // master table storage
  rofm_table u_table (
    .clk_i   (clk_i),
    .wr_i    (tbl_wr),
    .raddr_i (tbl_raddr),
    .rdata_o (tbl_rdata)
  );

  // request sequencer with the shared compare and subtract
  rofm_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (item_i),
    .wr_o        (tbl_wr),
    .raddr_o     (tbl_raddr),
    .rdata_i     (tbl_rdata),
    .res_o       (res),
    .res_ready_i (res_ready),
    .stat_o      (stat)
  );

  // output register takes a new result when empty or being drained
  assign res_ready = !out_valid_q || result_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res.valid) begin
      out_offs_q <= res.offset;
      out_idx_q  <= res.index;
    end
  end

  assign result_o.valid        = out_valid_q;
  assign result_o.offset       = out_offs_q;
  assign result_o.offset_index = out_idx_q;

  // fill count never passes the table size
  a_load_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.load_count <= rofm_pkg::LCNT_W'(rofm_pkg::MASTER_ENTRIES))
    else $error("load count beyond table size");

  // match count never passes the offset list size
  a_match_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.match_count <= rofm_pkg::MCNT_W'(rofm_pkg::OWN_ENTRIES))
    else $error("match count beyond offset list size");

  // no request taken while a scan is running
  a_busy_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.busy |-> !item_i.ready)
    else $error("request taken during scan");

  // a handed-off result shows on the port in the next cycle with its index
  a_handoff: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res.valid && res_ready) |=> (result_o.valid && result_o.offset_index == $past(res.index)))
    else $error("result lost at output register");

endmodule

[tb/sv/tb_reference_offset_matcher.sv]
// self-checking testbench for the reference offset matcher
`timescale 1ns / 100ps

module tb_reference_offset_matcher;

  // action code that the block must ignore
  localparam logic [rofm_pkg::ACT_W-1:0] ACT_RESERVED = 2'd3;

  // a no-match query scans every live entry, each one read then compared
  localparam int SETTLE_CYCLES = 4 * rofm_pkg::MASTER_ENTRIES + 16;
  localparam int CYCLE_LIMIT   = 600000;
  localparam int PHASE_ITEMS   = 500;

  // one expected offset result
  typedef struct {
    logic signed [rofm_pkg::OFFS_W-1:0] offset;
    logic [rofm_pkg::OIDX_W-1:0]        index;
  } offset_entry_t;

  // keeps its own copy of the master table, predicts offsets and checks them
  class offset_ledger;
    logic [rofm_pkg::ID_W-1:0] master_ids[rofm_pkg::MASTER_ENTRIES];
    logic [rofm_pkg::TS_W-1:0] master_stamps[rofm_pkg::MASTER_ENTRIES];
    bit                        live[rofm_pkg::MASTER_ENTRIES];
    int unsigned               load_count;
    int unsigned               match_count;
    offset_entry_t             pending_offsets[$];
    int                        mismatches;
    int                        requests, clears, loads, dropped_loads;
    int                        queries, matched, capped_queries, ignored;
    int                        offsets_checked;

    function void note_request(logic [rofm_pkg::ACT_W-1:0] act,
                               logic [rofm_pkg::ID_W-1:0] id,
                               logic [rofm_pkg::TS_W-1:0] stamp);
      int                        k;
      bit                        hit;
      logic [rofm_pkg::TS_W-1:0] diff;
      offset_entry_t             e;
      requests++;
      case (act)
        rofm_pkg::ACT_CLEAR: begin
          clears++;
          foreach (live[i]) live[i] = 1'b0;
          load_count  = 0;
          match_count = 0;
        end
        rofm_pkg::ACT_LOAD: begin
          loads++;
          if (load_count < rofm_pkg::MASTER_ENTRIES) begin
            master_ids[load_count]    = id;
            master_stamps[load_count] = stamp;
            live[load_count]          = 1'b1;
            load_count++;
          end else begin
            dropped_loads++;
          end
        end
        rofm_pkg::ACT_QUERY: begin
          queries++;
          if (match_count >= rofm_pkg::OWN_ENTRIES) begin
            capped_queries++;
          end else begin
            // first live entry with an equal id wins
            hit = 1'b0;
            for (k = 0; k < rofm_pkg::MASTER_ENTRIES && !hit; k++) begin
              if (live[k] && master_ids[k] == id) begin
                hit      = 1'b1;
                diff     = master_stamps[k] - stamp;
                e.offset = diff[rofm_pkg::OFFS_W-1:0];
                e.index  = match_count[rofm_pkg::OIDX_W-1:0];
                pending_offsets.push_back(e);
                match_count++;
                matched++;
              end
            end
          end
        end
        default: begin
          ignored++;
        end
      endcase
    endfunction

    function void check_offset(logic signed [rofm_pkg::OFFS_W-1:0] offset,
                               logic [rofm_pkg::OIDX_W-1:0] index);
      offset_entry_t e;
      offsets_checked++;
      if (pending_offsets.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected result: offset %0d index %0d", offset, index);
        mismatches++;
      end else begin
        e = pending_offsets.pop_front();
        if (offset !== e.offset || index !== e.index) begin
          if (mismatches < 10)
            $display("mismatch: expected offset %0d index %0d, got offset %0d index %0d",
                     e.offset, e.index, offset, index);
          mismatches++;
        end
      end
    endfunction

    function int pending_count();
      return pending_offsets.size();
    endfunction
  endclass

  logic         clk;
  logic         rst_n;
  int           source_gap_pct;
  int           sink_stall_pct;
  int           cycle_count;
  int           items_left;
  offset_ledger ledger;

  rofm_req_if req_if ();
  rofm_res_if res_if ();

  reference_offset_matcher dut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .item_i  (req_if),
    .result_o(res_if)
  );

  // 20 ns clock
  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // receiver stalls at random, at the rate of the current phase
  always @(posedge clk) begin
    res_if.ready <= ($urandom_range(99) >= sink_stall_pct);
  end

  // both channels are sampled at the edge, request side first
  always @(posedge clk) begin
    if (rst_n) begin
      if (req_if.valid && req_if.ready)
        ledger.note_request(req_if.action, req_if.ref_id, req_if.ref_time);
      if (res_if.valid && res_if.ready)
        ledger.check_offset(res_if.offset, res_if.offset_index);
    end
  end

  // watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles", cycle_count);
    $display("Some tests failed");
    $finish;
  end

  function automatic logic [63:0] random64();
    return {$urandom, $urandom};
  endfunction

  // ids: mostly wide random, some tiny, some all ones
  function automatic logic [rofm_pkg::ID_W-1:0] pick_id();
    case ($urandom_range(9))
      0:       return rofm_pkg::ID_W'($urandom_range(15));
      1:       return '1;
      default: return random64();
    endcase
  endfunction

  // one request, with an optional random gap in front of it
  task automatic send_request(input logic [rofm_pkg::ACT_W-1:0] act,
                              input logic [rofm_pkg::ID_W-1:0] id,
                              input logic [rofm_pkg::TS_W-1:0] stamp);
    if ($urandom_range(99) < source_gap_pct) begin
      req_if.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < source_gap_pct);
    end
    req_if.valid    <= 1'b1;
    req_if.action   <= act;
    req_if.ref_id   <= id;
    req_if.ref_time <= stamp;
    do @(posedge clk); while (!req_if.ready);
  endtask

  // stop sending until every predicted offset has come back
  task automatic drain_offsets();
    req_if.valid <= 1'b0;
    do @(posedge clk); while (ledger.pending_count() != 0);
  endtask

  // occasional reserved action code in between, not counted in the budget
  task automatic maybe_noise();
    if ($urandom_range(99) < 4) send_request(ACT_RESERVED, random64(), random64());
  endtask

  // one sync round: clear (in most rounds), fill the master table, then query local points
  task automatic run_sync_round(inout int budget);
    logic [rofm_pkg::ID_W-1:0] pool_id[$];
    logic [rofm_pkg::TS_W-1:0] pool_stamp[$];
    logic [rofm_pkg::ID_W-1:0] id;
    logic [rofm_pkg::TS_W-1:0] stamp;
    int                        n_loads;
    int                        n_queries;
    int                        pick;
    if ($urandom_range(99) < 85) begin
      send_request(rofm_pkg::ACT_CLEAR, random64(), random64());
      budget--;
    end
    // sometimes overfill so the table drops loads
    n_loads = ($urandom_range(99) < 15) ?
              $urandom_range(rofm_pkg::MASTER_ENTRIES + 1, rofm_pkg::MASTER_ENTRIES + 3) :
              $urandom_range(1, rofm_pkg::MASTER_ENTRIES);
    repeat (n_loads) begin
      if (pool_id.size() > 0 && $urandom_range(99) < 15)
        id = pool_id[$urandom_range(pool_id.size() - 1)];  // duplicate id
      else
        id = pick_id();
      stamp = random64();
      pool_id.push_back(id);
      pool_stamp.push_back(stamp);
      send_request(rofm_pkg::ACT_LOAD, id, stamp);
      budget--;
      maybe_noise();
    end
    // enough queries at times to run past the offset list size
    n_queries = $urandom_range(4, rofm_pkg::OWN_ENTRIES + 6);
    repeat (n_queries) begin
      if ($urandom_range(99) < 80) begin
        pick = $urandom_range(pool_id.size() - 1);
        id   = pool_id[pick];
        if ($urandom_range(1) == 0)
          stamp = pool_stamp[pick] - rofm_pkg::TS_W'($urandom_range(4000)) +
                  rofm_pkg::TS_W'(2000);
        else
          stamp = random64();
      end else begin
        id    = pick_id();
        stamp = random64();
      end
      send_request(rofm_pkg::ACT_QUERY, id, stamp);
      budget--;
      maybe_noise();
    end
  endtask

  initial begin
    ledger          = new();
    source_gap_pct  = 10;
    sink_stall_pct  = 78;
    rst_n           = 1'b0;
    req_if.valid    = 1'b0;
    req_if.action   = rofm_pkg::ACT_CLEAR;
    req_if.ref_id   = '0;
    req_if.ref_time = '0;
    res_if.ready    = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty table, reserved code, extreme ids and stamps
    send_request(rofm_pkg::ACT_QUERY, '0, '0);
    send_request(ACT_RESERVED, '1, '1);
    send_request(rofm_pkg::ACT_LOAD, '0, '0);
    send_request(rofm_pkg::ACT_LOAD, '1, '1);
    send_request(rofm_pkg::ACT_LOAD, 64'd5, 64'h0000_0001_0000_0000);
    send_request(rofm_pkg::ACT_LOAD, 64'd5, 64'd7);                  // duplicate id, loses
    send_request(rofm_pkg::ACT_QUERY, '0, '1);                       // offset +1
    send_request(rofm_pkg::ACT_QUERY, '1, '0);                       // offset -1
    send_request(rofm_pkg::ACT_QUERY, '1, 64'hFFFF_FFFF_8000_0000);  // largest positive
    send_request(rofm_pkg::ACT_QUERY, '1, 64'hFFFF_FFFF_7FFF_FFFF);  // most negative
    send_request(rofm_pkg::ACT_QUERY, 64'd5, '0);                    // wraps to zero
    send_request(rofm_pkg::ACT_QUERY, 64'h1234, random64());         // no match
    send_request(ACT_RESERVED, 64'h1234, random64());                // must not load
    send_request(rofm_pkg::ACT_QUERY, 64'h1234, random64());
    send_request(rofm_pkg::ACT_CLEAR, '1, '1);
    send_request(rofm_pkg::ACT_QUERY, '0, '0);                       // cleared table
    send_request(rofm_pkg::ACT_LOAD, '0, 64'd5);
    send_request(rofm_pkg::ACT_QUERY, '0, '0);                       // index back at zero
    drain_offsets();

    // random rounds in three idling phases
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin source_gap_pct = 10; sink_stall_pct = 78; end
        1: begin source_gap_pct = 78; sink_stall_pct = 10; end
        default: begin source_gap_pct = 0; sink_stall_pct = 0; end
      endcase
      items_left = PHASE_ITEMS;
      while (items_left > 0) run_sync_round(items_left);
      drain_offsets();
    end

    // let a trailing no-match scan finish
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("covered %0d requests: %0d clears, %0d loads (%0d dropped when full), %0d ignored",
             ledger.requests, ledger.clears, ledger.loads, ledger.dropped_loads, ledger.ignored);
    $display("%0d queries: %0d matched, %0d past the offset list; %0d offsets checked",
             ledger.queries, ledger.matched, ledger.capped_queries, ledger.offsets_checked);
    if (ledger.pending_count() != 0)
      $display("%0d expected offsets never arrived", ledger.pending_count());
    if (ledger.mismatches == 0 && ledger.pending_count() == 0) begin
      $display("All tests passed");
    end else begin
      $display("%0d mismatches", ledger.mismatches);
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
